// ----- rtl/llfr_pkg.sv -----
// ----------------------------------------------------------------------------
// llfr_pkg
// Shared types, link character codes and a hex-digit helper for the lab link frame
// receiver.
// ----------------------------------------------------------------------------
package llfr_pkg;

  localparam logic [7:0] CH_STX = 8'h02;
  localparam logic [7:0] CH_ETX = 8'h03;
  localparam logic [7:0] CH_EOT = 8'h04;
  localparam logic [7:0] CH_ENQ = 8'h05;
  localparam logic [7:0] CH_ACK = 8'h06;
  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_CR  = 8'h0D;
  localparam logic [7:0] CH_NAK = 8'h15;
  localparam logic [7:0] CH_ETB = 8'h17;

  typedef enum logic [1:0] {
    EV_ENQ    = 2'd0,
    EV_ACCEPT = 2'd1,
    EV_REJECT = 2'd2,
    EV_END    = 2'd3
  } event_t;

  typedef enum logic [3:0] {
    PH_IDLE  = 4'b0001,
    PH_BODY  = 4'b0010,
    PH_CHECK = 4'b0100,
    PH_TAIL  = 4'b1000
  } phase_t;

  typedef struct packed {
    logic       valid;
    event_t     ev;
    logic [7:0] sum;
  } frame_res_t;

  // upper-case ascii hex digit
  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    logic [7:0] r;
    if (nib < 4'd10) begin
      r = 8'h30 + {4'd0, nib};
    end else begin
      r = 8'h37 + {4'd0, nib};
    end
    return r;
  endfunction

endpackage

// ----- rtl/llfr_frame_fsm.sv -----
// ----------------------------------------------------------------------------
// llfr_frame_fsm
// Frame state and checksum logic: consumes one byte per step and reports
// the event it causes, if any.
// ----------------------------------------------------------------------------
module llfr_frame_fsm (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 step,
  input  logic [7:0]           byte_in,
  output llfr_pkg::frame_res_t res
);

  llfr_pkg::phase_t phase, phase_next;
  logic [7:0] running_sum, running_sum_next;
  logic [7:0] high_check_char, high_check_char_next;
  logic [1:0] check_char_count, check_char_count_next;
  logic       frame_bad, frame_bad_next;

  always_comb begin
    phase_next            = phase;
    running_sum_next      = running_sum;
    high_check_char_next  = high_check_char;
    check_char_count_next = check_char_count;
    frame_bad_next        = frame_bad;
    res.valid             = 1'b0;
    res.ev                = llfr_pkg::EV_ENQ;
    res.sum               = 8'd0;

    case (byte_in) inside
      llfr_pkg::CH_ENQ, llfr_pkg::CH_EOT, llfr_pkg::CH_ACK, llfr_pkg::CH_NAK: begin
        phase_next            = llfr_pkg::PH_IDLE;
        running_sum_next      = 8'd0;
        high_check_char_next  = 8'd0;
        check_char_count_next = 2'd0;
        frame_bad_next        = 1'b0;
        res.valid             = 1'b1;
        if (byte_in == llfr_pkg::CH_ENQ) begin
          res.ev = llfr_pkg::EV_ENQ;
        end else if (byte_in == llfr_pkg::CH_EOT) begin
          res.ev = llfr_pkg::EV_END;
        end else begin
          res.ev = llfr_pkg::EV_REJECT;
        end
      end
      llfr_pkg::CH_STX: begin
        if (phase == llfr_pkg::PH_IDLE) begin
          frame_bad_next = 1'b0;
        end
        phase_next            = llfr_pkg::PH_BODY;
        running_sum_next      = 8'd0;
        high_check_char_next  = 8'd0;
        check_char_count_next = 2'd0;
      end
      default: begin
        unique case (phase)
          llfr_pkg::PH_BODY: begin
            running_sum_next = running_sum + byte_in;
            if (byte_in == llfr_pkg::CH_ETX || byte_in == llfr_pkg::CH_ETB) begin
              phase_next            = llfr_pkg::PH_CHECK;
              check_char_count_next = 2'd0;
            end
          end
          llfr_pkg::PH_CHECK: begin
            if (byte_in == llfr_pkg::CH_LF) begin
              res.valid             = 1'b1;
              res.ev                = llfr_pkg::EV_REJECT;
              res.sum               = running_sum;
              phase_next            = llfr_pkg::PH_IDLE;
              running_sum_next      = 8'd0;
              high_check_char_next  = 8'd0;
              check_char_count_next = 2'd0;
              frame_bad_next        = 1'b0;
            end else if (check_char_count == 2'd0) begin
              high_check_char_next  = byte_in;
              check_char_count_next = 2'd1;
            end else begin
              if (high_check_char != llfr_pkg::hex_char(running_sum[7:4]) ||
                  byte_in != llfr_pkg::hex_char(running_sum[3:0])) begin
                frame_bad_next = 1'b1;
              end
              check_char_count_next = 2'd2;
              phase_next            = llfr_pkg::PH_TAIL;
            end
          end
          llfr_pkg::PH_TAIL: begin
            if (byte_in == llfr_pkg::CH_LF) begin
              res.valid             = 1'b1;
              res.ev                = frame_bad ? llfr_pkg::EV_REJECT : llfr_pkg::EV_ACCEPT;
              res.sum               = running_sum;
              phase_next            = llfr_pkg::PH_IDLE;
              running_sum_next      = 8'd0;
              high_check_char_next  = 8'd0;
              check_char_count_next = 2'd0;
              frame_bad_next        = 1'b0;
            end else if (byte_in != llfr_pkg::CH_CR) begin
              frame_bad_next = 1'b1;
            end
          end
          default: begin
            // idle: data without stx opens a bad frame
            phase_next            = llfr_pkg::PH_BODY;
            running_sum_next      = byte_in;
            high_check_char_next  = 8'd0;
            check_char_count_next = 2'd0;
            frame_bad_next        = 1'b1;
          end
        endcase
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= llfr_pkg::PH_IDLE;
      running_sum      <= 8'd0;
      high_check_char  <= 8'd0;
      check_char_count <= 2'd0;
      frame_bad        <= 1'b0;
    end else if (step) begin
      phase            <= phase_next;
      running_sum      <= running_sum_next;
      high_check_char  <= high_check_char_next;
      check_char_count <= check_char_count_next;
      frame_bad        <= frame_bad_next;
    end
  end

endmodule

// ----- rtl/lab_link_frame_receiver.sv -----
// ----------------------------------------------------------------------------
// lab_link_frame_receiver
// Low-level link framer: answers enquiries, checks frame checksums and
// reports accept, reject and end-of-transmission events.
// ----------------------------------------------------------------------------
// path: each byte is held in the input register, and its result in the result register
// throughput: one byte per cycle, set by the frame state update, unless a result waits untaken;
// bytes that cause no event advance even while a result waits at the output
// reset: synchronous, clears frame state and both valid flags
module lab_link_frame_receiver (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] rx_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] event_res,
  output logic [7:0] frame_sum
);

  logic                 byte_valid;
  logic [7:0]           byte_q;
  logic                 advance;
  llfr_pkg::frame_res_t res;

  llfr_frame_fsm u_fsm (
    .clk     (clk),
    .rst     (rst),
    .step    (advance),
    .byte_in (byte_q),
    .res     (res)
  );

  assign advance  = byte_valid && (!res.valid || !out_valid || out_ready);
  assign in_ready = !byte_valid || advance;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_valid <= 1'b0;
    end else if (in_ready) begin
      byte_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      byte_q <= rx_byte;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && res.valid) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res.valid) begin
      event_res <= res.ev;
      frame_sum <= res.sum;
    end
  end

endmodule
